[hw/rtl/htc_pkg.sv]
`default_nettype none
package htc_pkg;

  // Sizes
  localparam int MAX_VERTS   = 8;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NCOMP       = 6;
  localparam int VERT_W      = NCOMP * COORD_WIDTH;
  localparam int DEPTH       = 2 * MAX_VERTS;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(MAX_VERTS + 1);
  localparam int DIST_W      = COORD_WIDTH + 1;
  localparam int DEN_W       = COORD_WIDTH + 2;
  localparam int T_W         = FRAC_BITS + 1;
  localparam int PROD_W      = DIST_W + T_W + 1;
  localparam int STEP_W      = $clog2(FRAC_BITS + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIST_W-1:0] dist_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
    coord_t u;
    coord_t v;
  } vert_t;

  // Clip planes in pass order
  typedef enum logic [2:0] {
    PL_RIGHT,
    PL_LEFT,
    PL_TOP,
    PL_BOTTOM,
    PL_NEAR
  } plane_t;

  // Source of a vertex store write
  typedef enum logic [1:0] {
    WS_INPUT,
    WS_CLIP,
    WS_NEXT
  } wsel_t;

  typedef struct packed {
    logic             ram_we;
    wsel_t            wsel;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic             load_a;
    logic             load_b;
    logic             a_from_b;
    logic             div_start;
    logic             lerp_go;
    logic             gather_first;
    plane_t           plane;
    logic             out_load;
    logic             out_tri_end;
    logic             out_run_last;
  } cmd_t;

  typedef struct packed {
    logic tri_inside;
    logic a_in;
    logic b_in;
    logic div_done;
  } stat_t;

  function automatic dist_t sx(input coord_t c);
    sx = {c[COORD_WIDTH-1], c};
  endfunction

  // Signed distance to a plane, inside when >= 0
  function automatic dist_t plane_dist(input plane_t pl, input vert_t p);
    case (pl)
      PL_RIGHT:  plane_dist = sx(p.w) - sx(p.x);
      PL_LEFT:   plane_dist = sx(p.x) + sx(p.w);
      PL_TOP:    plane_dist = sx(p.w) - sx(p.y);
      PL_BOTTOM: plane_dist = sx(p.y) + sx(p.w);
      default:   plane_dist = sx(p.z) + sx(p.w);
    endcase
  endfunction

  // -w <= x, y, z <= w
  function automatic logic vert_inside(input vert_t p);
    dist_t far_d, r_d, l_d, t_d, b_d, n_d;
    far_d = sx(p.w) - sx(p.z);
    r_d   = plane_dist(PL_RIGHT, p);
    l_d   = plane_dist(PL_LEFT, p);
    t_d   = plane_dist(PL_TOP, p);
    b_d   = plane_dist(PL_BOTTOM, p);
    n_d   = plane_dist(PL_NEAR, p);
    vert_inside = !r_d[DIST_W-1] && !l_d[DIST_W-1] && !t_d[DIST_W-1] &&
                  !b_d[DIST_W-1] && !n_d[DIST_W-1] && !far_d[DIST_W-1];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/htc_ram.sv]
`default_nettype none
module htc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/htc_div.sv]
`default_nettype none
module htc_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [htc_pkg::DEN_W-1:0] num,
  input  wire logic [htc_pkg::DEN_W-1:0] den,
  output logic      [htc_pkg::T_W-1:0]   q,
  output logic                           done
);
  import htc_pkg::*;

  logic [DEN_W:0]    r;
  logic [DEN_W-1:0]  d;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DEN_W:0]    rr;
  logic              ge;

  // One quotient bit per cycle; first step takes the integer bit
  assign rr = (step == '0) ? r : {r[DEN_W-1:0], 1'b0};
  assign ge = rr >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r    <= {1'b0, num};
        d    <= den;
        q    <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        r    <= ge ? rr - {1'b0, d} : rr;
        q    <= {q[T_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/htc_datapath.sv]
`default_nettype none
module htc_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire htc_pkg::cmd_t   cmd,
  output htc_pkg::stat_t       stat,
  input  wire htc_pkg::coord_t vert_x,
  input  wire htc_pkg::coord_t vert_y,
  input  wire htc_pkg::coord_t vert_z,
  input  wire htc_pkg::coord_t vert_w,
  input  wire htc_pkg::coord_t vert_u,
  input  wire htc_pkg::coord_t vert_v,
  output htc_pkg::coord_t      out_x,
  output htc_pkg::coord_t      out_y,
  output htc_pkg::coord_t      out_z,
  output htc_pkg::coord_t      out_w,
  output htc_pkg::coord_t      out_u,
  output htc_pkg::coord_t      out_v,
  output logic                 tri_end,
  output logic                 run_last
);
  import htc_pkg::*;

  vert_t in_vert, rdata, wdata, a_reg, b_reg, clip_vert, out_vert;
  dist_t da, db;
  logic signed [DEN_W-1:0] da_e, db_e, num_s, den_s;
  logic [T_W-1:0] t_q;
  logic div_done;
  logic inside_acc, in_ok;
  logic signed [PROD_W-1:0] prod [NCOMP];

  assign in_vert = '{x: vert_x, y: vert_y, z: vert_z, w: vert_w, u: vert_u, v: vert_v};

  // Vertex store write source
  always_comb begin
    case (cmd.wsel)
      WS_INPUT: wdata = in_vert;
      WS_CLIP:  wdata = clip_vert;
      WS_NEXT:  wdata = b_reg;
      default:  wdata = in_vert;
    endcase
  end

  htc_ram #(.WIDTH(VERT_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (cmd.waddr),
    .wdata (wdata),
    .raddr (cmd.raddr),
    .rdata (rdata)
  );

  // Edge endpoints
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_reg <= rdata;
    end else if (cmd.a_from_b) begin
      a_reg <= b_reg;
    end
    if (cmd.load_b) begin
      b_reg <= rdata;
    end
  end

  // Trivial accept test over the gathered triangle
  assign in_ok = vert_inside(in_vert);
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_acc <= 1'b1;
    end else if (cmd.ram_we && cmd.wsel == WS_INPUT) begin
      inside_acc <= (cmd.gather_first ? 1'b1 : inside_acc) & in_ok;
    end
  end

  // Plane distances and divider operands
  assign da   = plane_dist(cmd.plane, a_reg);
  assign db   = plane_dist(cmd.plane, b_reg);
  assign da_e = {da[DIST_W-1], da};
  assign db_e = {db[DIST_W-1], db};
  assign num_s = stat.a_in ? da_e : -da_e;
  assign den_s = stat.a_in ? da_e - db_e : db_e - da_e;

  htc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_s),
    .den   (den_s),
    .q     (t_q),
    .done  (div_done)
  );

  // Interpolation: one multiplier per component, product registered
  for (genvar k = 0; k < NCOMP; k++) begin : g_lerp
    logic signed [COORD_WIDTH-1:0] ca, cb;
    logic signed [DIST_W-1:0]      diff;
    logic signed [PROD_W-1:0]      sum;
    assign ca   = a_reg[VERT_W-1-k*COORD_WIDTH -: COORD_WIDTH];
    assign cb   = b_reg[VERT_W-1-k*COORD_WIDTH -: COORD_WIDTH];
    assign diff = sx(cb) - sx(ca);
    always_ff @(posedge clk) begin
      if (cmd.lerp_go) begin
        prod[k] <= PROD_W'(diff * $signed({1'b0, t_q}));
      end
    end
    assign sum = PROD_W'(ca) + (prod[k] >>> FRAC_BITS);
    assign clip_vert[VERT_W-1-k*COORD_WIDTH -: COORD_WIDTH] = sum[COORD_WIDTH-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vert <= rdata;
      tri_end  <= cmd.out_tri_end;
      run_last <= cmd.out_run_last;
    end
  end

  assign out_x = out_vert.x;
  assign out_y = out_vert.y;
  assign out_z = out_vert.z;
  assign out_w = out_vert.w;
  assign out_u = out_vert.u;
  assign out_v = out_vert.v;

  assign stat.tri_inside = inside_acc & in_ok;
  assign stat.a_in       = !da[DIST_W-1];
  assign stat.b_in       = !db[DIST_W-1];
  assign stat.div_done   = div_done;

endmodule
`default_nettype wire

[hw/rtl/htc_ctrl.sv]
`default_nettype none
module htc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           vert_valid,
  output logic                vert_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire htc_pkg::stat_t stat,
  output htc_pkg::cmd_t       cmd
);
  import htc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_CAP_A,
    S_CAP_B,
    S_EDGE,
    S_DIV,
    S_LERP,
    S_PUSH_C,
    S_PUSH_B,
    S_EMIT_RD,
    S_EMIT_CAP
  } state_t;

  state_t state;
  logic [1:0]       gather_count;
  logic [CNT_W-1:0] poly_count, m, n, i, ei;
  logic [1:0]       ek;
  logic             bank;
  plane_t           plane, plane_next;
  logic             accept, take;
  logic [IDX_W-1:0] src, dst;
  logic [CNT_W-1:0] i_next, nb, m_after, m_final, eoff;
  logic             push_b, end_pass, emit_last;

  assign accept = vert_valid && !vert_stall;
  assign take   = out_valid && !out_stall;
  assign vert_stall = state != S_IDLE;

  assign src = bank ? IDX_W'(MAX_VERTS) : '0;
  assign dst = bank ? '0 : IDX_W'(MAX_VERTS);

  always_comb begin
    case (plane)
      PL_RIGHT:  plane_next = PL_LEFT;
      PL_LEFT:   plane_next = PL_TOP;
      PL_TOP:    plane_next = PL_BOTTOM;
      default:   plane_next = PL_NEAR;
    endcase
  end

  // Edge walk bookkeeping
  assign i_next  = i + 1'b1;
  assign nb      = (i_next + 1'b1 == n) ? '0 : i_next + 1'b1;
  assign push_b  = stat.b_in && (m < CNT_W'(MAX_VERTS));
  assign m_after = m + CNT_W'(push_b);
  assign end_pass = (state == S_PASS) ? (poly_count == '0) : (i_next == n);
  assign m_final  = (state == S_PASS) ? '0 : m_after;

  // Fan corner: v0, vi, vi+1
  always_comb begin
    case (ek)
      2'd0:    eoff = '0;
      2'd1:    eoff = ei;
      default: eoff = ei + 1'b1;
    endcase
  end
  assign emit_last = (ek == 2'd2) && (ei + CNT_W'(2) == poly_count);

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.plane = plane;
    cmd.wsel  = WS_INPUT;
    case (state)
      S_IDLE: begin
        cmd.ram_we       = accept;
        cmd.waddr        = IDX_W'(gather_count);
        cmd.gather_first = gather_count == 2'd0;
      end
      S_PASS:  cmd.raddr = src;
      S_CAP_A: begin
        cmd.load_a = 1'b1;
        cmd.raddr  = src + ((n == CNT_W'(1)) ? '0 : IDX_W'(1));
      end
      S_CAP_B: cmd.load_b = 1'b1;
      S_EDGE:  cmd.div_start = stat.a_in != stat.b_in;
      S_LERP:  cmd.lerp_go = 1'b1;
      S_PUSH_C: begin
        cmd.ram_we = m < CNT_W'(MAX_VERTS);
        cmd.waddr  = dst + IDX_W'(m);
        cmd.wsel   = WS_CLIP;
      end
      S_PUSH_B: begin
        cmd.ram_we   = push_b;
        cmd.waddr    = dst + IDX_W'(m);
        cmd.wsel     = WS_NEXT;
        cmd.a_from_b = 1'b1;
        cmd.raddr    = src + IDX_W'(nb);
      end
      S_EMIT_RD: cmd.raddr = src + IDX_W'(eoff);
      S_EMIT_CAP: begin
        cmd.out_load     = 1'b1;
        cmd.out_tri_end  = ek == 2'd2;
        cmd.out_run_last = emit_last;
      end
      default: ;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      gather_count <= '0;
      poly_count   <= '0;
      bank         <= 1'b0;
      plane        <= PL_RIGHT;
      m            <= '0;
      n            <= '0;
      i            <= '0;
      ei           <= '0;
      ek           <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (gather_count < 2'd2) begin
              gather_count <= gather_count + 1'b1;
            end else begin
              gather_count <= '0;
              bank         <= 1'b0;
              poly_count   <= CNT_W'(3);
              plane        <= PL_RIGHT;
              ei           <= CNT_W'(1);
              ek           <= '0;
              state        <= stat.tri_inside ? S_EMIT_RD : S_PASS;
            end
          end
        end
        S_PASS: begin
          m <= '0;
          i <= '0;
          n <= poly_count;
          if (!end_pass) state <= S_CAP_A;
        end
        S_CAP_A:  state <= S_CAP_B;
        S_CAP_B:  state <= S_EDGE;
        S_EDGE:   state <= (stat.a_in != stat.b_in) ? S_DIV : S_PUSH_B;
        S_DIV:    if (stat.div_done) state <= S_LERP;
        S_LERP:   state <= S_PUSH_C;
        S_PUSH_C: begin
          if (m < CNT_W'(MAX_VERTS)) m <= m + 1'b1;
          state <= S_PUSH_B;
        end
        S_PUSH_B: begin
          m <= m_after;
          i <= i_next;
          if (!end_pass) state <= S_CAP_B;
        end
        S_EMIT_RD: if (!out_valid || !out_stall) state <= S_EMIT_CAP;
        S_EMIT_CAP: begin
          if (ek == 2'd2) begin
            ek <= '0;
            ei <= ei + 1'b1;
          end else begin
            ek <= ek + 1'b1;
          end
          state <= emit_last ? S_IDLE : S_EMIT_RD;
        end
        default: state <= S_IDLE;
      endcase
      // Closing a clip pass
      if ((state == S_PASS || state == S_PUSH_B) && end_pass) begin
        poly_count <= m_final;
        bank       <= ~bank;
        ei         <= CNT_W'(1);
        ek         <= '0;
        if (plane == PL_NEAR) begin
          state <= (m_final >= CNT_W'(3)) ? S_EMIT_RD : S_IDLE;
        end else begin
          plane <= plane_next;
          state <= S_PASS;
        end
      end
    end
  end

  // Checks
  a_poly_bound: assert property (@(posedge clk) disable iff (rst)
    poly_count <= CNT_W'(MAX_VERTS))
    else $error("polygon size above capacity");

  a_gather_range: assert property (@(posedge clk) disable iff (rst)
    gather_count != 2'd3)
    else $error("gather count out of range");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("output register overwritten");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == S_DIV)
    else $error("divider finished outside wait state");

  a_clip_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.ram_we && state != S_IDLE) |-> m < CNT_W'(MAX_VERTS))
    else $error("clip write past polygon capacity");

endmodule
`default_nettype wire

[hw/rtl/homogeneous_triangle_clipper.sv]
`default_nettype none
// Homogeneous triangle clipper. Vertices (x, y, z, w, u, v, signed Q16.16) arrive one per
// item; every third closes a triangle. A triangle with -w <= x, y, z <= w at all three
// corners is sent out unchanged; any other is clipped against the right, left, top,
// bottom and near planes (no far plane) and the remaining polygon of up to 8 vertices is
// sent as a fan, one vertex per output item, tri_end on each third vertex and run_last on
// the final one; a polygon under three vertices sends nothing. In a clip pass, each edge
// that crosses the plane waits on the one-bit-per-cycle restoring divider that forms
// the intersection parameter; the vertex store gives one vertex per cycle, so the edges
// are walked one at a time. Each output vertex is read from the store, then loaded into
// the output register.
module homogeneous_triangle_clipper (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            vert_valid,
  output logic                 vert_stall,
  input  wire htc_pkg::coord_t vert_x,
  input  wire htc_pkg::coord_t vert_y,
  input  wire htc_pkg::coord_t vert_z,
  input  wire htc_pkg::coord_t vert_w,
  input  wire htc_pkg::coord_t vert_u,
  input  wire htc_pkg::coord_t vert_v,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output htc_pkg::coord_t      out_x,
  output htc_pkg::coord_t      out_y,
  output htc_pkg::coord_t      out_z,
  output htc_pkg::coord_t      out_w,
  output htc_pkg::coord_t      out_u,
  output htc_pkg::coord_t      out_v,
  output logic                 tri_end,
  output logic                 run_last
);
  import htc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  htc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .vert_valid (vert_valid),
    .vert_stall (vert_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  htc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .vert_x   (vert_x),
    .vert_y   (vert_y),
    .vert_z   (vert_z),
    .vert_w   (vert_w),
    .vert_u   (vert_u),
    .vert_v   (vert_v),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_w    (out_w),
    .out_u    (out_u),
    .out_v    (out_v),
    .tri_end  (tri_end),
    .run_last (run_last)
  );

endmodule
`default_nettype wire
